### hdl/srrip_pkg.sv
package srrip_pkg;

  typedef enum logic [1:0] {
    FUNC_HIT    = 2'd0,
    FUNC_MISS   = 2'd1,
    FUNC_INSERT = 2'd2,
    FUNC_INVAL  = 2'd3
  } func_e;

  localparam int unsigned SetInW = 10;
  localparam int unsigned WayInW = 3;

  // operation handed to the update logic along with the set word
  typedef struct packed {
    func_e              func;
    logic [WayInW-1:0]  way;
    logic               way_ok;
  } op_t;

endpackage

### hdl/srrip_ram.sv
module srrip_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read-during-write to the same entry returns the old word
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/srrip_update.sv
module srrip_update #(
  parameter int unsigned ASSOC     = 8,
  parameter int unsigned RRPV_BITS = 2
) (
  input  logic [ASSOC*RRPV_BITS-1:0]  word_i,
  input  srrip_pkg::op_t              op_i,
  output logic [ASSOC*RRPV_BITS-1:0]  word_o,
  output logic [srrip_pkg::WayInW-1:0] victim_way_o,
  output logic                        victim_valid_o
);

  localparam int unsigned WAY_W = $clog2(ASSOC);
  localparam logic [RRPV_BITS-1:0] RMAX = {RRPV_BITS{1'b1}};
  localparam logic [RRPV_BITS-1:0] RINS = RMAX - RRPV_BITS'(1);

  logic [ASSOC-1:0]     cand;
  logic [ASSOC-1:0]     hit;
  logic [RRPV_BITS-1:0] top;
  logic [RRPV_BITS-1:0] add;
  logic [WAY_W-1:0]     vic;
  logic [WAY_W-1:0]     way;

  // set maximum found bit by bit from the MSB; cand ends as the ways holding it
  always_comb begin
    cand = '1;
    top  = '0;
    hit  = '0;
    for (int b = RRPV_BITS - 1; b >= 0; b--) begin
      for (int w = 0; w < ASSOC; w++) begin
        hit[w] = cand[w] & word_i[w*RRPV_BITS + b];
      end
      if (|hit) begin
        top[b] = 1'b1;
        cand   = hit;
      end
    end
  end

  assign add = RMAX - top;

  // ways at the maximum become RMAX after aging; pick the lowest
  always_comb begin
    vic = '0;
    for (int w = ASSOC - 1; w >= 0; w--) begin
      if (cand[w]) begin
        vic = WAY_W'(w);
      end
    end
  end

  assign way = WAY_W'(op_i.way);

  always_comb begin
    word_o = word_i;
    case (op_i.func)
      srrip_pkg::FUNC_MISS: begin
        for (int w = 0; w < ASSOC; w++) begin
          word_o[w*RRPV_BITS +: RRPV_BITS] = word_i[w*RRPV_BITS +: RRPV_BITS] + add;
        end
      end
      srrip_pkg::FUNC_HIT: begin
        if (op_i.way_ok) word_o[way*RRPV_BITS +: RRPV_BITS] = '0;
      end
      srrip_pkg::FUNC_INSERT: begin
        if (op_i.way_ok) word_o[way*RRPV_BITS +: RRPV_BITS] = RINS;
      end
      srrip_pkg::FUNC_INVAL: begin
        if (op_i.way_ok) word_o[way*RRPV_BITS +: RRPV_BITS] = RMAX;
      end
      default: begin
        word_o = word_i;
      end
    endcase
  end

  assign victim_valid_o = (op_i.func == srrip_pkg::FUNC_MISS);
  assign victim_way_o   = victim_valid_o ? srrip_pkg::WayInW'(vic) : '0;

endmodule

### hdl/srrip_replacement_policy.sv
// SRRIP replacement state for a set-associative cache.
//
// Input channel (in_valid_i / in_ready_o): one request per access with
// func_i (hit, miss, insert, invalidate), set_index_i and way_index_i.
// Output channel (out_valid_o / out_ready_i): exactly one result per
// request, in order; victim_way_o / victim_valid_o carry the victim on a
// miss and zero otherwise.
//
// Throughput is one request per cycle while out_ready_i stays high. A
// request goes through an input register (set reduction), a memory read
// stage and a modify/write-back stage. A back-to-back request to the same
// set gets the just-written word by forwarding.
//
// After reset the block runs a clearing pass that writes every set to
// all-maximum values; in_ready_o stays low meanwhile.
// If out_ready_i is low the result register holds, and the pipeline behind
// it fills and then drops in_ready_o until the result is taken.
module srrip_replacement_policy #(
  parameter int unsigned NUM_SETS  = 1024,
  parameter int unsigned ASSOC     = 8,
  parameter int unsigned RRPV_BITS = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   func_i,
  input  logic [srrip_pkg::SetInW-1:0] set_index_i,
  input  logic [srrip_pkg::WayInW-1:0] way_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [srrip_pkg::WayInW-1:0] victim_way_o,
  output logic                         victim_valid_o
);

  localparam int unsigned SIN_W  = srrip_pkg::SetInW;
  localparam int unsigned SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WORD_W = ASSOC * RRPV_BITS;
  localparam int unsigned SH     = SIN_W + $clog2(NUM_SETS);
  localparam longint unsigned RECIP = ((64'd1 << SH) + NUM_SETS - 1) / NUM_SETS;
  localparam int unsigned RCP_W  = 12;
  localparam logic [RCP_W-1:0] RECIP_C = RCP_W'(RECIP);
  localparam logic [SIN_W-1:0] NSETS_LO = SIN_W'(NUM_SETS);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

  state_e state_q;
  logic [SET_W-1:0] clr_cnt_q;

  // stage A: accepted request with quotient of set / NUM_SETS
  logic                        a_valid_q;
  srrip_pkg::func_e            a_func_q;
  logic [SIN_W-1:0]            a_raw_q;
  logic [SIN_W-1:0]            a_quo_q;
  logic [srrip_pkg::WayInW-1:0] a_way_q;
  logic [SIN_W+RCP_W-1:0]      quo_prod;
  logic [SIN_W-1:0]            a_rem;
  logic [SET_W-1:0]            a_set;

  // stage B: memory word available, modify and write back
  logic                 b_valid_q;
  srrip_pkg::op_t       b_op_q;
  logic [SET_W-1:0]     b_set_q;
  logic                 fwd_valid_q;
  logic [WORD_W-1:0]    fwd_word_q;
  logic [WORD_W-1:0]    rd_word;
  logic [WORD_W-1:0]    b_word;
  logic [WORD_W-1:0]    new_word;
  logic [srrip_pkg::WayInW-1:0] upd_way;
  logic                 upd_valid;

  logic                 out_valid_q;
  logic [srrip_pkg::WayInW-1:0] victim_way_q;
  logic                 victim_valid_q;

  logic accept;
  logic a_adv;
  logic b_commit;
  logic clearing;
  logic wr_en;
  logic [SET_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;

  assign clearing   = (state_q == ST_CLEAR);
  assign b_commit   = b_valid_q && (!out_valid_q || out_ready_i);
  assign a_adv      = !b_valid_q || b_commit;
  assign in_ready_o = !clearing && (!a_valid_q || a_adv);
  assign accept     = in_valid_i && in_ready_o;

  // exact floor(set / NUM_SETS) for any 10-bit set via reciprocal multiply
  assign quo_prod = set_index_i * RECIP_C;
  assign a_rem    = a_raw_q - SIN_W'(a_quo_q * NSETS_LO);
  assign a_set    = SET_W'(a_rem);

  assign b_word = fwd_valid_q ? fwd_word_q : rd_word;

  assign wr_en   = clearing || b_commit;
  assign wr_addr = clearing ? clr_cnt_q : b_set_q;
  assign wr_data = clearing ? '1 : new_word;

  srrip_ram #(
    .DEPTH  (NUM_SETS),
    .WIDTH  (WORD_W),
    .ADDR_W (SET_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (a_valid_q && a_adv),
    .rd_addr_i (a_set),
    .rd_data_o (rd_word)
  );

  srrip_update #(
    .ASSOC     (ASSOC),
    .RRPV_BITS (RRPV_BITS)
  ) u_update (
    .word_i         (b_word),
    .op_i           (b_op_q),
    .word_o         (new_word),
    .victim_way_o   (upd_way),
    .victim_valid_o (upd_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else if (clearing) begin
      clr_cnt_q <= clr_cnt_q + SET_W'(1);
      if (clr_cnt_q == LAST_SET) state_q <= ST_RUN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
      if (a_adv) begin
        b_valid_q <= a_valid_q;
        // word written this edge is what the read below should have seen
        fwd_valid_q <= a_valid_q && b_commit && (b_set_q == a_set);
      end
      if (b_commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_func_q <= srrip_pkg::func_e'(func_i);
      a_raw_q  <= set_index_i;
      a_quo_q  <= SIN_W'(quo_prod >> SH);
      a_way_q  <= way_index_i;
    end
    if (a_adv && a_valid_q) begin
      b_op_q.func   <= a_func_q;
      b_op_q.way    <= a_way_q;
      b_op_q.way_ok <= (32'(a_way_q) < ASSOC);
      b_set_q       <= a_set;
      fwd_word_q    <= new_word;
    end
    if (b_commit) begin
      victim_way_q   <= upd_way;
      victim_valid_q <= upd_valid;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign victim_way_o   = victim_way_q;
  assign victim_valid_o = victim_valid_q;

endmodule

### tb/tb_srrip_replacement_policy.sv
`timescale 1ns / 1ps

module tb_srrip_replacement_policy;

  localparam int NSETS      = 1024;
  localparam int NWAYS      = 8;
  localparam int RBITS      = 2;
  localparam int RAND_ITEMS = 1500;
  localparam int QUIET_TAIL = 200;
  localparam int LONG_HOLD  = 300;
  localparam int IDLE_LIMIT = 5000;
  localparam int PIPE_LAT   = 3;

  localparam logic [RBITS-1:0] RRPV_MAX = '1;
  localparam logic [RBITS-1:0] RRPV_INS = RRPV_MAX - 1'b1;

  typedef struct packed {
    logic [srrip_pkg::WayInW-1:0] way;
    logic                         valid;
  } victim_t;

  typedef struct packed {
    srrip_pkg::func_e             f;
    logic [srrip_pkg::SetInW-1:0] s;
    logic [srrip_pkg::WayInW-1:0] w;
    logic                         typed;
    logic [srrip_pkg::WayInW-1:0] ew;
    logic                         ev;
  } dir_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  srrip_pkg::func_e             func_i;
  logic [srrip_pkg::SetInW-1:0] set_index_i;
  logic [srrip_pkg::WayInW-1:0] way_index_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [srrip_pkg::WayInW-1:0] victim_way_o;
  logic                         victim_valid_o;

  // expectation typed into the directed table, travels with the request
  logic                         req_typed;
  logic [srrip_pkg::WayInW-1:0] req_exp_way;
  logic                         req_exp_valid;

  logic [NWAYS-1:0][RBITS-1:0] rrpv_ref [NSETS];
  victim_t  victim_q [$];
  dir_row_t dir_tab [$];
  int       errors;
  int       idle_cycles;
  bit       hold_req;
  bit       quiet;

  srrip_replacement_policy #(
    .NUM_SETS (NSETS),
    .ASSOC    (NWAYS),
    .RRPV_BITS(RBITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .set_index_i   (set_index_i),
    .way_index_i   (way_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .victim_way_o  (victim_way_o),
    .victim_valid_o(victim_valid_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic victim_t predict_victim(srrip_pkg::func_e f,
                                             logic [srrip_pkg::SetInW-1:0] s,
                                             logic [srrip_pkg::WayInW-1:0] w);
    victim_t          r;
    logic [RBITS-1:0] top;
    logic [RBITS-1:0] gap;
    int               set_no;
    bit               found;
    r      = '0;
    set_no = s % NSETS;
    if (f == srrip_pkg::FUNC_MISS) begin
      top = '0;
      for (int i = 0; i < NWAYS; i++)
        if (rrpv_ref[set_no][i] > top) top = rrpv_ref[set_no][i];
      // one step of aging brings the oldest way to max
      gap = RRPV_MAX - top;
      for (int i = 0; i < NWAYS; i++) rrpv_ref[set_no][i] = rrpv_ref[set_no][i] + gap;
      found = 1'b0;
      for (int i = 0; i < NWAYS; i++)
        if (!found && rrpv_ref[set_no][i] == RRPV_MAX) begin
          r.way = i[srrip_pkg::WayInW-1:0];
          found = 1'b1;
        end
      r.valid = 1'b1;
    end else if (w < NWAYS) begin
      case (f)
        srrip_pkg::FUNC_HIT:    rrpv_ref[set_no][w] = '0;
        srrip_pkg::FUNC_INSERT: rrpv_ref[set_no][w] = RRPV_INS;
        default:                rrpv_ref[set_no][w] = RRPV_MAX;
      endcase
    end
    return r;
  endfunction

  function automatic dir_row_t mk_row(srrip_pkg::func_e f, int s, int w, int typed,
                                      int ew, int ev);
    dir_row_t r;
    r.f     = f;
    r.s     = s[srrip_pkg::SetInW-1:0];
    r.w     = w[srrip_pkg::WayInW-1:0];
    r.typed = typed[0];
    r.ew    = ew[srrip_pkg::WayInW-1:0];
    r.ev    = ev[0];
    return r;
  endfunction

  function automatic srrip_pkg::func_e pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return srrip_pkg::FUNC_HIT;
    if (r < 65) return srrip_pkg::FUNC_MISS;
    if (r < 85) return srrip_pkg::FUNC_INSERT;
    return srrip_pkg::FUNC_INVAL;
  endfunction

  task automatic send_req(srrip_pkg::func_e f, logic [srrip_pkg::SetInW-1:0] s,
                          logic [srrip_pkg::WayInW-1:0] w, logic typed,
                          logic [srrip_pkg::WayInW-1:0] ew, logic ev);
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    func_i        <= f;
    set_index_i   <= s;
    way_index_i   <= w;
    req_typed     <= typed;
    req_exp_way   <= ew;
    req_exp_valid <= ev;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic rest(int n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (victim_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < NSETS; i++)
      for (int j = 0; j < NWAYS; j++) rrpv_ref[i][j] = RRPV_MAX;
  end

  // receiver: random backpressure bursts, one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      if (hold_req) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk_i);
      end else begin
        @(negedge clk_i);
        out_ready_i <= 1'b1;
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : scoreboard
    victim_t got;
    victim_t want;
    victim_t pred;
    if (out_valid_o && out_ready_i) begin
      got.way   = victim_way_o;
      got.valid = victim_valid_o;
      if (victim_q.size() == 0) begin
        $display("%0t: result without pending request: way %0d valid %0b",
                 $time, got.way, got.valid);
        errors++;
      end else begin
        want = victim_q.pop_front();
        if (got.way !== want.way) begin
          $display("%0t: victim_way expected %0d actual %0d", $time, want.way, got.way);
          errors++;
        end
        if (got.valid !== want.valid) begin
          $display("%0t: victim_valid expected %0b actual %0b",
                   $time, want.valid, got.valid);
          errors++;
        end
      end
    end
    if (in_valid_i && in_ready_o) begin
      pred = predict_victim(func_i, set_index_i, way_index_i);
      if (req_typed) begin
        pred.way   = req_exp_way;
        pred.valid = req_exp_valid;
      end
      victim_q.push_back(pred);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stim
    dir_row_t                     row;
    srrip_pkg::func_e             f;
    logic [srrip_pkg::SetInW-1:0] s;
    logic [srrip_pkg::SetInW-1:0] hot_sets [4];
    in_valid_i    = 1'b0;
    func_i        = srrip_pkg::FUNC_HIT;
    set_index_i   = '0;
    way_index_i   = '0;
    req_typed     = 1'b0;
    req_exp_way   = '0;
    req_exp_valid = 1'b0;
    rst_ni        = 1'b0;
    errors        = 0;
    idle_cycles   = 0;
    hold_req      = 1'b0;
    quiet         = 1'b0;

    // everything at max after reset: first miss picks way 0
    dir_tab.push_back(mk_row(srrip_pkg::FUNC_MISS,   0,    0, 1, 0, 1));
    dir_tab.push_back(mk_row(srrip_pkg::FUNC_HIT,    0,    0, 1, 0, 0));
    dir_tab.push_back(mk_row(srrip_pkg::FUNC_MISS,   0,    5, 0, 0, 0));
    dir_tab.push_back(mk_row(srrip_pkg::FUNC_INVAL,  0,    0, 1, 0, 0));
    dir_tab.push_back(mk_row(srrip_pkg::FUNC_MISS,   0,    3, 0, 0, 0));
    dir_tab.push_back(mk_row(srrip_pkg::FUNC_HIT,    1023, 7, 1, 0, 0));
    dir_tab.push_back(mk_row(srrip_pkg::FUNC_INSERT, 1023, 0, 1, 0, 0));
    dir_tab.push_back(mk_row(srrip_pkg::FUNC_MISS,   1023, 7, 0, 0, 0));
    // fill a set with no way at max so the miss has to age it
    for (int i = 0; i < 4; i++)
      dir_tab.push_back(mk_row(srrip_pkg::FUNC_HIT, 682, i, 1, 0, 0));
    for (int i = 4; i < 8; i++)
      dir_tab.push_back(mk_row(srrip_pkg::FUNC_INSERT, 682, i, 1, 0, 0));
    dir_tab.push_back(mk_row(srrip_pkg::FUNC_MISS,   682,  0, 0, 0, 0));
    dir_tab.push_back(mk_row(srrip_pkg::FUNC_HIT,    682,  4, 1, 0, 0));
    dir_tab.push_back(mk_row(srrip_pkg::FUNC_MISS,   682,  2, 0, 0, 0));
    dir_tab.push_back(mk_row(srrip_pkg::FUNC_INSERT, 341,  7, 1, 0, 0));
    dir_tab.push_back(mk_row(srrip_pkg::FUNC_MISS,   341,  7, 0, 0, 0));
    dir_tab.push_back(mk_row(srrip_pkg::FUNC_INVAL,  341,  7, 1, 0, 0));
    dir_tab.push_back(mk_row(srrip_pkg::FUNC_MISS,   341,  1, 0, 0, 0));

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int n = 0; n < dir_tab.size(); n++) begin
      row = dir_tab[n];
      send_req(row.f, row.s, row.w, row.typed, row.ew, row.ev);
    end

    // a few hot sets keep the replacement state busy; the rest spread wide
    hot_sets[0] = '0;
    hot_sets[1] = '1;
    hot_sets[2] = srrip_pkg::SetInW'($urandom_range(0, NSETS - 1));
    hot_sets[3] = srrip_pkg::SetInW'($urandom_range(0, NSETS - 1));
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 400) hold_req = 1'b1;
      if (n == 900) drain();
      if (n >= RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;
      else if ($urandom_range(0, 7) == 0) rest($urandom_range(1, 12));
      f = pick_func();
      if ($urandom_range(0, 99) < 85) s = hot_sets[2'($urandom_range(0, 3))];
      else s = srrip_pkg::SetInW'($urandom_range(0, NSETS - 1));
      send_req(f, s, srrip_pkg::WayInW'($urandom_range(0, NWAYS - 1)), 1'b0, '0, 1'b0);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (victim_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT * 4) @(posedge clk_i);
    if (errors == 0 && victim_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
